### rtl/core/nsfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsfq_pkg: shared types and constants for the NMEA sentence framer queue
// Holds the ring geometry, derived widths, request and status codes, the
// controller states and small addressing helpers.
// ----------------------------------------------------------------------------
package nsfq_pkg;

  // Ring geometry
  localparam int NUM_SLOTS      = 8;
  localparam int SLOT_BYTES     = 128;
  localparam int MAX_WORDS      = 16;   // cap on data beats per pop

  // Derived widths
  localparam int SLOT_W         = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int FILL_W         = $clog2(SLOT_BYTES + 1);
  localparam int WORDS_PER_SLOT = (SLOT_BYTES + 7) / 8;
  localparam int WIDX_W         = (WORDS_PER_SLOT > 1) ? $clog2(WORDS_PER_SLOT) : 1;
  localparam int STORE_WORDS    = NUM_SLOTS * WORDS_PER_SLOT;
  localparam int STORE_AW       = $clog2(STORE_WORDS);

  // Framing characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  typedef enum logic [1:0] {
    REQ_BYTE  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    STAT_DATA     = 3'd0,
    STAT_TAKEN    = 3'd1,
    STAT_STORED   = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_LONG     = 3'd4,
    STAT_EMPTY    = 3'd5,
    STAT_DISABLED = 3'd6,
    STAT_FLUSHED  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COPY,
    S_COPY_END,
    S_POP
  } fsm_state_t;

  // Advance a ring position with wrap
  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(NUM_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

  // Word address of a slot's word in the sentence store
  function automatic logic [STORE_AW-1:0] store_addr(input logic [SLOT_W-1:0] s,
                                                     input logic [WIDX_W-1:0] i);
    int a;
    a = int'(s) * WORDS_PER_SLOT + int'(i);
    return STORE_AW'(a);
  endfunction

endpackage

### rtl/core/nmea_sentence_framer_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_framer_queue_top: NMEA sentence framer with a slot ring
// Frames received bytes into sentences and queues them in fixed slots;
// pops the oldest sentence as 64-bit data beats.
// ----------------------------------------------------------------------------
// Each request beat on the slave side carries a kind in s_tuser (receive
// byte, pop, flush) and a byte in s_tdata. A '$' opens a sentence, CR then LF
// closes it; bytes are packed eight to a word into a one-slot line buffer
// memory, and a finished sentence is copied word by word into the next free
// slot of the sentence store memory. Byte, flush and empty-pop requests
// give one result beat, registered, in the cycle after the request is
// taken. Storing a sentence then occupies the copy sequencer (one line
// buffer read per word, each store write in the cycle after its read),
// during which no request is taken. A pop of a sentence of L bytes gives
// min(ceil(L/8),16) data beats, one per cycle while the master side is
// ready; the first word is fetched from the store into its read register
// and then loaded into the output register. tlast marks the final beat;
// no request is taken until that beat is loaded. The store has no reset
// and needs no clearing pass: only bytes inside a stored length are ever
// delivered, the rest of a word is masked to zero. queue_full and
// queue_empty in each result reflect the ring after the request.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_queue_top
  import nsfq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel: queue_enable
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  // Request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  // Result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [63:0] data_word, [67:64] byte_count,
                                 // [75:68] sentence_length, [76] queue_full,
                                 // [77] queue_empty, [79:78] zero
  output logic [2:0]  m_tuser,   // [2:0] status
  output logic        m_tlast    // last
);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  fsm_state_t          state, state_next;
  logic                queue_enable;

  logic [NUM_SLOTS-1:0] slot_written;
  logic [FILL_W-1:0]    slot_length [NUM_SLOTS];
  logic [SLOT_W-1:0]    write_slot;
  logic [SLOT_W-1:0]    read_slot;
  logic [FILL_W-1:0]    fill_position;
  logic                 in_sentence;
  logic                 previous_was_cr;
  logic [63:0]          asm_word;          // word being assembled

  // Copy sequencer
  logic [SLOT_W-1:0]    copy_slot;
  logic [WIDX_W-1:0]    copy_idx;
  logic [WIDX_W-1:0]    copy_last;
  logic                 copy_pend;
  logic [WIDX_W-1:0]    copy_pend_idx;

  // Pop sequencer
  logic [SLOT_W-1:0]    pop_slot;
  logic [FILL_W-1:0]    pop_len;
  logic [WIDX_W-1:0]    pop_idx;
  logic [WIDX_W-1:0]    pop_last;

  // Output register
  logic                 out_valid;
  status_t              out_status;
  logic [63:0]          out_word;
  logic [3:0]           out_count;
  logic                 out_last;
  logic [7:0]           out_len;

  // Memories
  logic [63:0]          line_mem  [WORDS_PER_SLOT];
  logic [63:0]          store_mem [STORE_WORDS];
  logic [63:0]          line_q;
  logic [63:0]          store_q;

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic        s_accept;
  logic        out_free;
  req_t        req;
  logic [7:0]  rx;

  assign req      = req_t'(s_tuser);
  assign rx       = s_tdata;
  assign s_accept = s_tvalid & s_tready;
  assign out_free = !out_valid || m_tready;

  // --------------------------------------------------------------------------
  // Byte framing: next framer state for a received byte
  // --------------------------------------------------------------------------
  status_t           b_status;
  logic [FILL_W-1:0] b_fill;
  logic              b_in;
  logic              b_prev;
  logic [63:0]       b_asm;
  logic [63:0]       merged;
  logic              b_line_we;
  logic              b_store;
  logic [FILL_W-1:0] stored_len;
  logic [2:0]        lane;

  assign lane       = fill_position[2:0];
  assign stored_len = fill_position + 1'b1;

  always_comb begin
    merged                      = asm_word;
    merged[{lane, 3'b000} +: 8] = rx;
    b_status  = STAT_TAKEN;
    b_fill    = fill_position;
    b_in      = in_sentence;
    b_prev    = previous_was_cr;
    b_asm     = asm_word;
    b_line_we = 1'b0;
    b_store   = 1'b0;
    if (rx != CH_NUL) begin
      b_prev = (rx == CH_CR);
      if (rx == CH_DOLLAR) begin
        // open a sentence, dropping any partial one
        b_in       = 1'b1;
        b_fill     = FILL_W'(1);
        b_asm[7:0] = rx;
      end else if (in_sentence) begin
        if (fill_position >= FILL_W'(SLOT_BYTES)) begin
          b_in     = 1'b0;
          b_fill   = '0;
          b_status = STAT_LONG;
        end else begin
          b_asm  = merged;
          b_fill = stored_len;
          if (lane == 3'd7) begin
            b_line_we = 1'b1;
          end
          if (rx == CH_LF && previous_was_cr) begin
            // flush the tail word and close the sentence
            b_line_we = 1'b1;
            b_in      = 1'b0;
            b_fill    = '0;
            if (slot_written[write_slot]) begin
              b_status = STAT_FULL;
            end else begin
              b_status = STAT_STORED;
              b_store  = 1'b1;
            end
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pop beat formatting
  // --------------------------------------------------------------------------
  logic [FILL_W-1:0] pop_rem;
  logic [3:0]        pop_count;
  logic [63:0]       pop_word;
  logic [FILL_W-1:0] head_len;
  logic [FILL_W-1:0] head_last;

  assign pop_rem   = pop_len - FILL_W'({pop_idx, 3'b000});
  assign pop_count = (pop_rem >= FILL_W'(8)) ? 4'd8 : 4'(pop_rem);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pop_word[8*i +: 8] = (4'(i) < pop_count) ? store_q[8*i +: 8] : 8'h00;
    end
  end

  // last word index of the slot at the read position, capped at the beat limit
  assign head_len  = slot_length[read_slot];
  always_comb begin
    head_last = (head_len - 1'b1) >> 3;
    if (head_last > FILL_W'(MAX_WORDS - 1)) begin
      head_last = FILL_W'(MAX_WORDS - 1);
    end
  end

  // --------------------------------------------------------------------------
  // Controller: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_accept && queue_enable && req == REQ_BYTE && b_store) begin
          state_next = S_COPY;
        end else if (s_accept && queue_enable && req == REQ_POP &&
                     slot_written[read_slot]) begin
          state_next = S_POP;
        end
      end
      S_COPY: begin
        if (copy_idx == copy_last) begin
          state_next = S_COPY_END;
        end
      end
      S_COPY_END: begin
        state_next = S_IDLE;
      end
      S_POP: begin
        if (out_free && pop_idx == pop_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Controller: outputs
  // --------------------------------------------------------------------------
  logic                 o_load;
  status_t              o_status;
  logic [63:0]          o_word;
  logic [3:0]           o_count;
  logic                 o_last;
  logic [7:0]           o_len;
  logic                 byte_go;
  logic                 pop_go;
  logic                 flush_go;
  logic                 line_re;
  logic [WIDX_W-1:0]    line_raddr;
  logic                 store_re;
  logic [STORE_AW-1:0]  store_raddr;

  always_comb begin
    s_tready    = 1'b0;
    o_load      = 1'b0;
    o_status    = STAT_TAKEN;
    o_word      = '0;
    o_count     = '0;
    o_last      = 1'b1;
    o_len       = '0;
    byte_go     = 1'b0;
    pop_go      = 1'b0;
    flush_go    = 1'b0;
    line_re     = 1'b0;
    line_raddr  = copy_idx;
    store_re    = 1'b0;
    store_raddr = store_addr(read_slot, '0);
    case (state)
      S_IDLE: begin
        s_tready = out_free;
        if (s_accept && req != REQ_NONE) begin
          if (!queue_enable) begin
            o_load   = 1'b1;
            o_status = STAT_DISABLED;
          end else begin
            case (req)
              REQ_BYTE: begin
                byte_go  = 1'b1;
                o_load   = 1'b1;
                o_status = b_status;
                o_len    = b_store ? 8'(stored_len) : 8'd0;
              end
              REQ_POP: begin
                if (slot_written[read_slot]) begin
                  // fetch the first word; beats follow from S_POP
                  pop_go   = 1'b1;
                  store_re = 1'b1;
                end else begin
                  o_load   = 1'b1;
                  o_status = STAT_EMPTY;
                end
              end
              REQ_FLUSH: begin
                flush_go = 1'b1;
                o_load   = 1'b1;
                o_status = STAT_FLUSHED;
              end
              default: begin
                o_load = 1'b0;
              end
            endcase
          end
        end
      end
      S_COPY: begin
        line_re = 1'b1;
      end
      S_COPY_END: begin
        line_re = 1'b0;
      end
      S_POP: begin
        if (out_free) begin
          o_load   = 1'b1;
          o_status = STAT_DATA;
          o_word   = pop_word;
          o_count  = pop_count;
          o_last   = (pop_idx == pop_last);
          o_len    = 8'(pop_len);
          if (pop_idx != pop_last) begin
            store_re    = 1'b1;
            store_raddr = store_addr(pop_slot, pop_idx + 1'b1);
          end
        end
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      queue_enable    <= 1'b1;
      slot_written    <= '0;
      write_slot      <= '0;
      read_slot       <= '0;
      fill_position   <= '0;
      in_sentence     <= 1'b0;
      previous_was_cr <= 1'b0;
      copy_pend       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state     <= state_next;
      copy_pend <= (state == S_COPY);
      if (cfg_valid && cfg_ready) begin
        queue_enable <= cfg_data;
      end
      if (o_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (byte_go) begin
        fill_position   <= b_fill;
        in_sentence     <= b_in;
        previous_was_cr <= b_prev;
        if (b_store) begin
          slot_written[write_slot] <= 1'b1;
          write_slot               <= slot_inc(write_slot);
        end
      end
      if (pop_go) begin
        slot_written[read_slot] <= 1'b0;
        read_slot               <= slot_inc(read_slot);
      end
      if (flush_go) begin
        // empty the ring; a sentence being assembled carries on
        slot_written <= '0;
        write_slot   <= '0;
        read_slot    <= '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (byte_go) begin
      asm_word <= b_asm;
      if (b_store) begin
        slot_length[write_slot] <= stored_len;
        copy_slot               <= write_slot;
        copy_last               <= fill_position[WIDX_W+2:3];
      end
    end
    if (state == S_IDLE) begin
      copy_idx <= '0;
    end else if (state == S_COPY && copy_idx != copy_last) begin
      copy_idx <= copy_idx + 1'b1;
    end
    copy_pend_idx <= copy_idx;
    if (pop_go) begin
      pop_slot <= read_slot;
      pop_len  <= head_len;
      pop_idx  <= '0;
      pop_last <= head_last[WIDX_W-1:0];
    end else if (state == S_POP && out_free && pop_idx != pop_last) begin
      pop_idx <= pop_idx + 1'b1;
    end
    if (o_load) begin
      out_status <= o_status;
      out_word   <= o_word;
      out_count  <= o_count;
      out_last   <= o_last;
      out_len    <= o_len;
    end
  end

  // --------------------------------------------------------------------------
  // Line buffer memory: one slot of words being assembled
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (byte_go && b_line_we) begin
      line_mem[fill_position[WIDX_W+2:3]] <= merged;
    end
    if (line_re) begin
      line_q <= line_mem[line_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Sentence store memory: NUM_SLOTS slots of words
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (copy_pend) begin
      store_mem[store_addr(copy_slot, copy_pend_idx)] <= line_q;
    end
    if (store_re) begin
      store_q <= store_mem[store_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Result port
  // --------------------------------------------------------------------------
  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;
  assign m_tdata  = {2'b00, !slot_written[read_slot], slot_written[write_slot],
                     out_len, out_count, out_word};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_copy_claims_slot: assert property (@(posedge clk) disable iff (rst)
    copy_pend |-> slot_written[copy_slot])
    else $error("copy into a slot that is not claimed");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_position <= FILL_W'(SLOT_BYTES))
    else $error("fill position beyond slot size");

  a_fill_idle: assert property (@(posedge clk) disable iff (rst)
    !in_sentence |-> fill_position == '0)
    else $error("fill position held outside a sentence");

  a_pop_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> pop_idx <= pop_last)
    else $error("pop index past last word");

  a_data_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == STAT_DATA) |-> (out_count != 4'd0 && out_count <= 4'd8))
    else $error("data beat with bad byte count");

endmodule
